// ===== hw/rtl/pca_pkg.sv =====
// ----------------------------------------------------------------------------
// pca_pkg
// Shared types, widths and constants for the pixel color adjust pipeline.
// ----------------------------------------------------------------------------
package pca_pkg;

  localparam int PIPE_DEPTH = 5;

  localparam int CHAN_W   = 8;
  localparam int GAIN_W   = 16;
  localparam int FRAC_W   = 12;
  localparam int CFG_IDX_W = 2;

  localparam int LUMA_W   = 21;
  localparam int SCALED_W = 24;
  localparam int DIFF_W   = 25;
  localparam int PROD1_W  = 42;
  localparam int Q1_W     = 30;
  localparam int SMM_W    = 31;
  localparam int PROD2_W  = 48;
  localparam int Q2_W     = 36;
  localparam int CON_W    = 37;
  localparam int OUT_Q_W  = 25;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd4096;

  localparam logic [11:0] LUMA_WT_RED   = 12'd870;
  localparam logic [11:0] LUMA_WT_GREEN = 12'd2930;
  localparam logic [11:0] LUMA_WT_BLUE  = 12'd295;

  localparam int MID_GREY_Q12 = 522240;
  localparam int HALF_LSB     = 2048;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_SATURATION = 2'd1,
    REG_CONTRAST   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [PIPE_DEPTH-1:0] valid;
    logic [PIPE_DEPTH-1:0] load;
    logic                  in_ready;
  } pca_ctrl_t;

endpackage

// ===== hw/rtl/pca_ctrl.sv =====
// ----------------------------------------------------------------------------
// pca_ctrl
// Valid bits and per-stage load enables; bubbles collapse, stalls hold.
// ----------------------------------------------------------------------------
module pca_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_ready,
  output pca_pkg::pca_ctrl_t  ctrl
);

  logic [pca_pkg::PIPE_DEPTH-1:0] valid_r;
  logic [pca_pkg::PIPE_DEPTH-1:0] valid_nxt;
  logic [pca_pkg::PIPE_DEPTH:0]   ready;
  logic [pca_pkg::PIPE_DEPTH-1:0] feed;
  logic [pca_pkg::PIPE_DEPTH-1:0] load;

  always_comb begin
    ready[pca_pkg::PIPE_DEPTH] = out_ready;
    for (int k = pca_pkg::PIPE_DEPTH - 1; k >= 0; k--) begin
      ready[k] = !valid_r[k] || ready[k+1];
    end
    feed = {valid_r[pca_pkg::PIPE_DEPTH-2:0], in_valid};
    load = ready[pca_pkg::PIPE_DEPTH-1:0] & feed;
    for (int k = 0; k < pca_pkg::PIPE_DEPTH; k++) begin
      valid_nxt[k] = ready[k] ? feed[k] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign ctrl.valid    = valid_r;
  assign ctrl.load     = load;
  assign ctrl.in_ready = ready[0];

endmodule

// ===== hw/rtl/pca_chan.sv =====
// ----------------------------------------------------------------------------
// pca_chan
// One color channel: brightness scale, saturation, contrast, round and clamp.
// ----------------------------------------------------------------------------
module pca_chan (
  input  logic                              clk,
  input  pca_pkg::pca_ctrl_t                ctrl,
  input  logic [pca_pkg::GAIN_W-1:0]        brightness_gain,
  input  logic [pca_pkg::GAIN_W-1:0]        saturation_gain,
  input  logic [pca_pkg::GAIN_W-1:0]        contrast_gain,
  input  logic [pca_pkg::CHAN_W-1:0]        chan_in,
  input  logic [pca_pkg::LUMA_W-1:0]        luma_s1,
  input  logic [pca_pkg::LUMA_W-1:0]        luma_s2,
  input  logic                              pass_s4,
  output logic [pca_pkg::CHAN_W-1:0]        chan_out
);

  logic [pca_pkg::CHAN_W-1:0]          c_r [pca_pkg::PIPE_DEPTH-1];
  logic [pca_pkg::SCALED_W-1:0]        scaled_s1_r;
  logic signed [pca_pkg::PROD1_W-1:0]  prod1_s2_r;
  logic signed [pca_pkg::SMM_W-1:0]    smm_s3_r;
  logic signed [pca_pkg::PROD2_W-1:0]  prod2_s4_r;
  logic [pca_pkg::CHAN_W-1:0]          res_s5_r;

  logic [pca_pkg::SCALED_W-1:0]        scaled_nxt;
  logic signed [pca_pkg::DIFF_W-1:0]   diff;
  logic signed [pca_pkg::GAIN_W:0]     sat_gain_s;
  logic signed [pca_pkg::GAIN_W:0]     con_gain_s;
  logic signed [pca_pkg::PROD1_W-1:0]  prod1_nxt;
  logic signed [pca_pkg::PROD1_W-1:0]  p1_rnd;
  logic signed [pca_pkg::Q1_W-1:0]     q1;
  logic signed [pca_pkg::SMM_W-1:0]    smm_nxt;
  logic signed [pca_pkg::PROD2_W-1:0]  prod2_nxt;
  logic signed [pca_pkg::PROD2_W-1:0]  p2_rnd;
  logic signed [pca_pkg::Q2_W-1:0]     q2;
  logic signed [pca_pkg::CON_W-1:0]    con;
  logic signed [pca_pkg::CON_W-1:0]    con_rnd;
  logic signed [pca_pkg::OUT_Q_W-1:0]  o_q;
  logic [pca_pkg::CHAN_W-1:0]          res_nxt;

  always_comb begin
    scaled_nxt = pca_pkg::SCALED_W'(chan_in) * pca_pkg::SCALED_W'(brightness_gain);

    sat_gain_s = $signed({1'b0, saturation_gain});
    con_gain_s = $signed({1'b0, contrast_gain});

    diff = $signed({1'b0, scaled_s1_r})
         - pca_pkg::DIFF_W'($signed({1'b0, luma_s1}));
    prod1_nxt = pca_pkg::PROD1_W'(diff) * pca_pkg::PROD1_W'(sat_gain_s);

    p1_rnd  = prod1_s2_r + pca_pkg::PROD1_W'(pca_pkg::HALF_LSB);
    q1      = pca_pkg::Q1_W'(p1_rnd >>> pca_pkg::FRAC_W);
    smm_nxt = pca_pkg::SMM_W'(q1)
            + pca_pkg::SMM_W'($signed({1'b0, luma_s2}))
            - pca_pkg::SMM_W'(pca_pkg::MID_GREY_Q12);

    prod2_nxt = pca_pkg::PROD2_W'(smm_s3_r) * pca_pkg::PROD2_W'(con_gain_s);

    p2_rnd  = prod2_s4_r + pca_pkg::PROD2_W'(pca_pkg::HALF_LSB);
    q2      = pca_pkg::Q2_W'(p2_rnd >>> pca_pkg::FRAC_W);
    con     = pca_pkg::CON_W'(q2) + pca_pkg::CON_W'(pca_pkg::MID_GREY_Q12);
    con_rnd = con + pca_pkg::CON_W'(pca_pkg::HALF_LSB);
    o_q     = pca_pkg::OUT_Q_W'(con_rnd >>> pca_pkg::FRAC_W);

    if (pass_s4) begin
      res_nxt = c_r[pca_pkg::PIPE_DEPTH-2];
    end else if (o_q < 0) begin
      res_nxt = '0;
    end else if (o_q > pca_pkg::OUT_Q_W'(255)) begin
      res_nxt = '1;
    end else begin
      res_nxt = o_q[pca_pkg::CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      c_r[0]      <= chan_in;
      scaled_s1_r <= scaled_nxt;
    end
    if (ctrl.load[1]) begin
      prod1_s2_r <= prod1_nxt;
    end
    if (ctrl.load[2]) begin
      smm_s3_r <= smm_nxt;
    end
    if (ctrl.load[3]) begin
      prod2_s4_r <= prod2_nxt;
    end
    if (ctrl.load[4]) begin
      res_s5_r <= res_nxt;
    end
  end

  for (genvar k = 1; k < pca_pkg::PIPE_DEPTH - 1; k++) begin : g_c_pipe
    always_ff @(posedge clk) begin
      if (ctrl.load[k]) begin
        c_r[k] <= c_r[k-1];
      end
    end
  end

  assign chan_out = res_s5_r;

endmodule

// ===== hw/rtl/pixel_color_adjust_unit.sv =====
// ----------------------------------------------------------------------------
// pixel_color_adjust_unit
// Brightness, saturation and contrast adjustment of RGBA pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one RGBA pixel per transaction (valid/ready).
//   Output channel out_*: one adjusted pixel per transaction, in order.
//   Config port cfg_*: write gains (brightness, saturation, contrast,
//   unsigned Q4.12) while the pipeline is empty; indexes above 2 are ignored.
//   Throughput: one pixel per cycle while out_ready is high; five register
//   stages (scale and luma, saturation multiply, luma add, contrast
//   multiply, round and clamp).
//   A pixel with alpha zero passes through unchanged.
//   Reset: all stages empty, gains return to 1.0.
//   Stall: when out_ready is low the output holds; earlier stages keep
//   filling empty slots, and in_ready falls only once all five are full.
// ----------------------------------------------------------------------------
module pixel_color_adjust_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pca_pkg::CHAN_W-1:0]          in_red,
  input  logic [pca_pkg::CHAN_W-1:0]          in_green,
  input  logic [pca_pkg::CHAN_W-1:0]          in_blue,
  input  logic [pca_pkg::CHAN_W-1:0]          in_alpha,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pca_pkg::CHAN_W-1:0]          out_red,
  output logic [pca_pkg::CHAN_W-1:0]          out_green,
  output logic [pca_pkg::CHAN_W-1:0]          out_blue,
  output logic [pca_pkg::CHAN_W-1:0]          out_alpha,
  input  logic                                cfg_we,
  input  logic [pca_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pca_pkg::GAIN_W-1:0]          cfg_data
);

  pca_pkg::pca_ctrl_t ctrl;

  logic [pca_pkg::GAIN_W-1:0] bright_gain_r;
  logic [pca_pkg::GAIN_W-1:0] sat_gain_r;
  logic [pca_pkg::GAIN_W-1:0] con_gain_r;

  logic [pca_pkg::LUMA_W-1:0] luma_nxt;
  logic [pca_pkg::LUMA_W-1:0] luma_s1_r;
  logic [pca_pkg::LUMA_W-1:0] luma_s2_r;
  logic [pca_pkg::CHAN_W-1:0] alpha_r [pca_pkg::PIPE_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_gain_r <= pca_pkg::GAIN_ONE;
      sat_gain_r    <= pca_pkg::GAIN_ONE;
      con_gain_r    <= pca_pkg::GAIN_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pca_pkg::REG_BRIGHTNESS: bright_gain_r <= cfg_data;
        pca_pkg::REG_SATURATION: sat_gain_r    <= cfg_data;
        pca_pkg::REG_CONTRAST:   con_gain_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  assign luma_nxt = pca_pkg::LUMA_W'(in_red)   * pca_pkg::LUMA_W'(pca_pkg::LUMA_WT_RED)
                  + pca_pkg::LUMA_W'(in_green) * pca_pkg::LUMA_W'(pca_pkg::LUMA_WT_GREEN)
                  + pca_pkg::LUMA_W'(in_blue)  * pca_pkg::LUMA_W'(pca_pkg::LUMA_WT_BLUE);

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      luma_s1_r  <= luma_nxt;
      alpha_r[0] <= in_alpha;
    end
    if (ctrl.load[1]) begin
      luma_s2_r <= luma_s1_r;
    end
  end

  for (genvar k = 1; k < pca_pkg::PIPE_DEPTH; k++) begin : g_alpha_pipe
    always_ff @(posedge clk) begin
      if (ctrl.load[k]) begin
        alpha_r[k] <= alpha_r[k-1];
      end
    end
  end

  logic pass_s4;
  assign pass_s4 = (alpha_r[pca_pkg::PIPE_DEPTH-2] == '0);

  pca_chan u_red (
    .clk             (clk),
    .ctrl            (ctrl),
    .brightness_gain (bright_gain_r),
    .saturation_gain (sat_gain_r),
    .contrast_gain   (con_gain_r),
    .chan_in         (in_red),
    .luma_s1         (luma_s1_r),
    .luma_s2         (luma_s2_r),
    .pass_s4         (pass_s4),
    .chan_out        (out_red)
  );

  pca_chan u_green (
    .clk             (clk),
    .ctrl            (ctrl),
    .brightness_gain (bright_gain_r),
    .saturation_gain (sat_gain_r),
    .contrast_gain   (con_gain_r),
    .chan_in         (in_green),
    .luma_s1         (luma_s1_r),
    .luma_s2         (luma_s2_r),
    .pass_s4         (pass_s4),
    .chan_out        (out_green)
  );

  pca_chan u_blue (
    .clk             (clk),
    .ctrl            (ctrl),
    .brightness_gain (bright_gain_r),
    .saturation_gain (sat_gain_r),
    .contrast_gain   (con_gain_r),
    .chan_in         (in_blue),
    .luma_s1         (luma_s1_r),
    .luma_s2         (luma_s2_r),
    .pass_s4         (pass_s4),
    .chan_out        (out_blue)
  );

  assign in_ready  = ctrl.in_ready;
  assign out_valid = ctrl.valid[pca_pkg::PIPE_DEPTH-1];
  assign out_alpha = alpha_r[pca_pkg::PIPE_DEPTH-1];

`ifndef SYNTHESIS
  a_ready_when_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(&ctrl.valid) |-> in_ready)
    else $error("in_ready low with an empty stage");

  a_ready_follows_sink: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while sink ready");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> ctrl.valid[0])
    else $error("accepted transaction lost at first stage");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

// ===== verif/pixel_color_adjust_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_color_adjust_checker
// Watches the gain writes and both pixel channels of the color adjust unit.
// Keeps its own gain registers and predicts every adjusted pixel in fixed
// point. Compares each output transaction field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module pixel_color_adjust_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [pca_pkg::CHAN_W-1:0]    in_red,
  input  logic [pca_pkg::CHAN_W-1:0]    in_green,
  input  logic [pca_pkg::CHAN_W-1:0]    in_blue,
  input  logic [pca_pkg::CHAN_W-1:0]    in_alpha,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [pca_pkg::CHAN_W-1:0]    out_red,
  input  logic [pca_pkg::CHAN_W-1:0]    out_green,
  input  logic [pca_pkg::CHAN_W-1:0]    out_blue,
  input  logic [pca_pkg::CHAN_W-1:0]    out_alpha,
  input  logic                          cfg_we,
  input  logic [pca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pca_pkg::GAIN_W-1:0]    cfg_data,
  output int unsigned                   mismatches,
  output int unsigned                   pending,
  output int unsigned                   checked
);
  import pca_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } pixel_t;

  logic [GAIN_W-1:0] brightness = GAIN_ONE;
  logic [GAIN_W-1:0] saturation = GAIN_ONE;
  logic [GAIN_W-1:0] contrast   = GAIN_ONE;
  pixel_t            adjusted_q[$];
  int unsigned       fail_total = 0;
  int unsigned       checked_total = 0;

  function automatic longint round_q12(longint v);
    return (v + HALF_LSB) >>> FRAC_W;
  endfunction

  function automatic logic [CHAN_W-1:0] adjust_channel(logic [CHAN_W-1:0] c, longint luma);
    longint scaled;
    longint sat;
    longint con;
    longint level;
    scaled = longint'(c) * longint'(brightness);
    sat    = luma + round_q12((scaled - luma) * longint'(saturation));
    con    = MID_GREY_Q12 + round_q12((sat - MID_GREY_Q12) * longint'(contrast));
    level  = round_q12(con);
    if (level < 0) return '0;
    if (level > 255) return '1;
    return level[CHAN_W-1:0];
  endfunction

  function automatic pixel_t adjust_pixel(pixel_t src);
    pixel_t res;
    longint luma;
    res = src;
    if (src.alpha != '0) begin
      luma = longint'(src.red) * longint'(LUMA_WT_RED)
           + longint'(src.green) * longint'(LUMA_WT_GREEN)
           + longint'(src.blue) * longint'(LUMA_WT_BLUE);
      res.red   = adjust_channel(src.red, luma);
      res.green = adjust_channel(src.green, luma);
      res.blue  = adjust_channel(src.blue, luma);
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    fail_total++;
    $display("checker: %s mismatch on pixel %0d: got %0d, expected %0d",
             what, checked_total, got, want);
  endtask

  always @(posedge clk) begin : watch
    pixel_t src;
    pixel_t got;
    pixel_t want;
    if (!rst_n) begin
      brightness = GAIN_ONE;
      saturation = GAIN_ONE;
      contrast   = GAIN_ONE;
      adjusted_q.delete();
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BRIGHTNESS: brightness = cfg_data;
          REG_SATURATION: saturation = cfg_data;
          REG_CONTRAST:   contrast   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        src.red   = in_red;
        src.green = in_green;
        src.blue  = in_blue;
        src.alpha = in_alpha;
        adjusted_q.push_back(adjust_pixel(src));
      end
      if (out_valid && out_ready) begin
        got.red   = out_red;
        got.green = out_green;
        got.blue  = out_blue;
        got.alpha = out_alpha;
        if (adjusted_q.size() == 0) begin
          report_mismatch("unexpected pixel, red", got.red, -1);
        end else begin
          want = adjusted_q.pop_front();
          if (got.red != want.red) report_mismatch("red", got.red, want.red);
          if (got.green != want.green) report_mismatch("green", got.green, want.green);
          if (got.blue != want.blue) report_mismatch("blue", got.blue, want.blue);
          if (got.alpha != want.alpha) report_mismatch("alpha", got.alpha, want.alpha);
        end
        checked_total++;
      end
    end
    mismatches <= fail_total;
    pending    <= adjusted_q.size();
    checked    <= checked_total;
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the pixel color adjust unit.
// Runs a few directed pixels under default and extreme gains, then random
// pixels under random gain settings, with bursty input and a stalling
// receiver. The checker beside the unit predicts and compares every pixel.
// ----------------------------------------------------------------------------
module tb;
  import pca_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_PIXELS  = 216;
  localparam int TIMEOUT_NS    = 5_000_000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CHAN_W-1:0]    in_red = '0;
  logic [CHAN_W-1:0]    in_green = '0;
  logic [CHAN_W-1:0]    in_blue = '0;
  logic [CHAN_W-1:0]    in_alpha = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CHAN_W-1:0]    out_red;
  logic [CHAN_W-1:0]    out_green;
  logic [CHAN_W-1:0]    out_blue;
  logic [CHAN_W-1:0]    out_alpha;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0]    cfg_data = '0;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned burst_left = 0;
  int unsigned gain_settings = 1;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;

  pixel_color_adjust_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .in_alpha  (in_alpha),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pixel_color_adjust_checker pixel_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .in_alpha   (in_alpha),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_alpha  (out_alpha),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: always ready, random stalls, then long hold runs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    case ((cycle_count / 300) % 3)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (hold_left == 0) begin
          hold_left <= $urandom_range(1, 12);
          out_ready <= !out_ready;
        end else begin
          hold_left <= hold_left - 1;
        end
      end
    endcase
  end

  task automatic send_pixel(input logic [CHAN_W-1:0] r, g, b, a);
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    in_alpha <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(10, 40)) @(posedge clk);
      else
        repeat ($urandom_range(1, 4)) @(posedge clk);
      burst_left = $urandom_range(0, 32);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic apply_gains(input logic [GAIN_W-1:0] b, s, c);
    drain();
    write_gain(REG_BRIGHTNESS, b);
    write_gain(REG_SATURATION, s);
    write_gain(REG_CONTRAST, c);
    gain_settings++;
  endtask

  task automatic send_directed();
    send_pixel(8'd0, 8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd128, 8'd1);
    send_pixel(8'd17, 8'd200, 8'd3, 8'd0);
    send_pixel(8'd128, 8'd128, 8'd127, 8'd128);
  endtask

  function automatic logic [CHAN_W-1:0] random_channel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  function automatic logic [CHAN_W-1:0] random_alpha();
    if ($urandom_range(0, 5) == 0) return '0;
    return random_channel();
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return GAIN_ONE;
      3, 4: return GAIN_W'($urandom_range(0, 3 * 4096));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    send_directed();

    drain();
    write_gain(REG_BRIGHTNESS, '0);
    write_gain(REG_SATURATION, 16'd8192);
    write_gain(REG_CONTRAST, GAIN_ONE);
    write_gain(REG_SPARE, 16'h1234);
    gain_settings++;
    send_directed();

    apply_gains('1, '1, '1);
    send_directed();
    apply_gains('0, '0, '0);
    send_directed();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_gains(random_gain(), random_gain(), random_gain());
      repeat (PHASE_PIXELS)
        send_pixel(random_channel(), random_channel(), random_channel(), random_alpha());
    end

    drain();
    repeat (4 * PIPE_DEPTH) @(posedge clk);
    $display("tb summary: %0d pixels checked under %0d gain settings", checked, gain_settings);
    $display("tb summary: transparent, clamped and spare-index cases included");
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule
